// ===== hdl/salru_pkg.sv =====
// Shared types, constants and codes for the set-associative LRU cache simulator.
package salru_pkg;

    // Default sizing of the line arrays.
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_WAY_COUNT  = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

    // Configuration reset values.
    localparam logic [2:0] RST_SET_BITS   = 3'd4;
    localparam logic [3:0] RST_WAY_COUNT  = 4'd1;
    localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

    // Access kinds of a trace record.
    localparam logic [1:0] ACT_IGNORE = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_STORE  = 2'd2;
    localparam logic [1:0] ACT_MODIFY = 2'd3;

    // One trace record.
    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] address;
    } request_t;

    // One result beat.
    typedef struct packed {
        logic        first_hit;
        logic        evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } result_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Control from the sequencer to the way compare unit.
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    // Status from the way compare unit to the sequencer.
    typedef struct packed {
        logic hit_now;
        logic hit;
        logic inv_found;
    } scan_stat_t;

endpackage

// ===== hdl/salru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/salru_scan.sv =====
// Way compare unit: checks one way per step for a hit, a free line and the LRU victim.
module salru_scan #(
    parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  salru_pkg::scan_ctl_t                       ctl,
    input  logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] way,
    input  logic                                       line_valid,
    input  logic [63:0]                                line_tag,
    input  logic [31:0]                                line_stamp,
    input  logic [63:0]                                tag,
    output salru_pkg::scan_stat_t                      stat,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] hit_way,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] inv_way,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] victim_way
);

    import salru_pkg::*;

    localparam int WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic          hit_reg, hit_next;
    logic          inv_found_reg, inv_found_next;
    logic [WB-1:0] hit_way_reg, hit_way_next;
    logic [WB-1:0] inv_way_reg, inv_way_next;
    logic [WB-1:0] victim_reg, victim_next;
    logic [31:0]   min_stamp_reg, min_stamp_next;
    logic          hit_now;

    // A hit needs a valid line with an equal tag.
    assign hit_now = ctl.step && line_valid && (line_tag == tag);

    // Track hit, first free way and the way with the oldest stamp.
    always_comb
    begin
        hit_next       = hit_reg;
        inv_found_next = inv_found_reg;
        hit_way_next   = hit_way_reg;
        inv_way_next   = inv_way_reg;
        victim_next    = victim_reg;
        min_stamp_next = min_stamp_reg;
        if (ctl.clear)
        begin
            hit_next       = 1'b0;
            inv_found_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (hit_now)
            begin
                hit_next     = 1'b1;
                hit_way_next = way;
            end
            if (!line_valid && !inv_found_reg)
            begin
                inv_found_next = 1'b1;
                inv_way_next   = way;
            end
            // Strict compare keeps the lowest way on a tie.
            if ((way == '0) || (line_stamp < min_stamp_reg))
            begin
                min_stamp_next = line_stamp;
                victim_next    = way;
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            inv_found_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            inv_found_reg <= inv_found_next;
        end
    end

    // Way numbers and running minimum.
    always_ff @(posedge clk)
    begin
        hit_way_reg   <= hit_way_next;
        inv_way_reg   <= inv_way_next;
        victim_reg    <= victim_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign stat.hit_now   = hit_now;
    assign stat.hit       = hit_reg;
    assign stat.inv_found = inv_found_reg;
    assign hit_way        = hit_way_reg;
    assign inv_way        = inv_way_reg;
    assign victim_way     = victim_reg;

endmodule

// ===== hdl/set_assoc_lru_cache_sim_core.sv =====
// An ignore record gives its result beat in the cycle after it is taken; a load or
// store passes through a split state, a scan of the ways (cut short on an early hit) and
// a write state. A modify repeats the scan and write. The ways are read one at a time
// from the tag and stamp RAMs, and no new record is taken while busy is high, so a load,
// store or modify finishes before the next is taken; an ignore record is taken every cycle.
// Reset is asynchronous; afterwards a clearing pass zeroes the valid rows with busy high.
// Result beats cannot be stalled by the receiver.
module set_assoc_lru_cache_sim_core #(
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  salru_pkg::request_t request,
    output logic                done,
    output salru_pkg::result_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data
);

    import salru_pkg::*;

    localparam int SB     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WB     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW     = WB + 1;
    localparam int LAW    = SB + WB;
    localparam int LDEPTH = 1 << LAW;
    localparam int SETS   = 1 << SB;

    // Configuration registers.
    logic [2:0] set_bits_reg;
    logic [3:0] way_count_reg;
    logic [5:0] block_bits_reg;

    // Sequencer control state.
    state_t        state_reg, state_next;
    logic [SB-1:0] clr_idx_reg, clr_idx_next;
    logic [CW-1:0] rd_way_reg, rd_way_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          pass_reg, pass_next;
    logic          modify_reg, modify_next;
    logic          done_reg, done_next;
    logic          first_hit_reg, first_hit_next;
    logic          evicted_reg, evicted_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic [31:0]   hit_count_reg, hit_count_next;
    logic [31:0]   miss_count_reg, miss_count_next;
    logic [31:0]   evict_count_reg, evict_count_next;

    // Access payload.
    logic [63:0]   block_reg, block_next;
    logic [SB-1:0] set_reg, set_next;
    logic [63:0]   tag_reg, tag_next;
    logic [WB-1:0] cmp_way_reg, cmp_way_next;

    // Effective configuration.
    logic [4:0]    ways_raw;
    logic [CW-1:0] ways_eff;
    logic [3:0]    sb_eff;
    logic [SB-1:0] set_mask;
    logic          accept;
    logic          issue;
    logic          last_way;

    // RAM ports.
    logic          line_we, line_re, tag_we;
    logic [LAW-1:0] line_waddr, line_raddr;
    logic [63:0]   tag_rdata;
    logic [31:0]   stamp_rdata;
    logic          vrow_we, vrow_re;
    logic [SB-1:0] vrow_waddr;
    logic [MAX_WAYS-1:0] vrow_wdata, vrow_rdata;

    // Compare unit.
    scan_ctl_t     scan_ctl;
    scan_stat_t    scan_stat;
    logic [WB-1:0] hit_way, inv_way, victim_way, tgt_way;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Clamp way count and set bits to what the arrays hold.
    always_comb
    begin
        ways_raw = {1'b0, way_count_reg};
        if (ways_raw == 5'd0)
        begin
            ways_raw = 5'd1;
        end
        else if (ways_raw > 5'(MAX_WAYS))
        begin
            ways_raw = 5'(MAX_WAYS);
        end
        ways_eff = CW'(ways_raw);
        sb_eff   = {1'b0, set_bits_reg};
        if (sb_eff > 4'(MAX_SET_BITS))
        begin
            sb_eff = 4'(MAX_SET_BITS);
        end
        set_mask = ~({SB{1'b1}} << sb_eff);
    end

    assign issue    = (rd_way_reg < ways_eff);
    assign last_way = ((CW'(cmp_way_reg) + CW'(1)) == ways_eff);

    // Way chosen for the write: hit way, else first free way, else LRU victim.
    always_comb
    begin
        if (scan_stat.hit)
        begin
            tgt_way = hit_way;
        end
        else if (scan_stat.inv_found)
        begin
            tgt_way = inv_way;
        end
        else
        begin
            tgt_way = victim_way;
        end
    end

    assign line_raddr = {set_reg, rd_way_reg[WB-1:0]};
    assign line_waddr = {set_reg, tgt_way};

    // Sequencer next state and RAM controls.
    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        rd_way_next      = rd_way_reg;
        cmp_vld_next     = 1'b0;
        cmp_way_next     = cmp_way_reg;
        pass_next        = pass_reg;
        modify_next      = modify_reg;
        done_next        = 1'b0;
        first_hit_next   = first_hit_reg;
        evicted_next     = evicted_reg;
        stamp_next       = stamp_reg;
        hit_count_next   = hit_count_reg;
        miss_count_next  = miss_count_reg;
        evict_count_next = evict_count_reg;
        block_next       = block_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        line_we          = 1'b0;
        tag_we           = 1'b0;
        line_re          = 1'b0;
        vrow_we          = 1'b0;
        vrow_re          = 1'b0;
        vrow_waddr       = set_reg;
        vrow_wdata       = vrow_rdata | (MAX_WAYS'(1) << tgt_way);
        scan_ctl.clear   = 1'b0;
        scan_ctl.step    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                vrow_we    = 1'b1;
                vrow_waddr = clr_idx_reg;
                vrow_wdata = '0;
                clr_idx_next = clr_idx_reg + SB'(1);
                if (clr_idx_reg == {SB{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    first_hit_next = 1'b0;
                    evicted_next   = 1'b0;
                    block_next     = request.address >> block_bits_reg;
                    modify_next    = (request.action == ACT_MODIFY);
                    pass_next      = 1'b0;
                    if (request.action == ACT_IGNORE)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT:
            begin
                set_next       = block_reg[SB-1:0] & set_mask;
                tag_next       = block_reg >> sb_eff;
                rd_way_next    = '0;
                scan_ctl.clear = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_ctl.step = cmp_vld_reg;
                if (cmp_vld_reg && (scan_stat.hit_now || last_way))
                begin
                    state_next = ST_WRITE;
                end
                else if (issue)
                begin
                    line_re      = 1'b1;
                    vrow_re      = (rd_way_reg == '0);
                    cmp_vld_next = 1'b1;
                    cmp_way_next = rd_way_reg[WB-1:0];
                    rd_way_next  = rd_way_reg + CW'(1);
                end
            end
            ST_WRITE:
            begin
                stamp_next = stamp_reg + 32'd1;
                line_we    = 1'b1;
                if (scan_stat.hit)
                begin
                    hit_count_next = hit_count_reg + 32'd1;
                end
                else
                begin
                    miss_count_next = miss_count_reg + 32'd1;
                    tag_we          = 1'b1;
                    vrow_we         = 1'b1;
                    if (!scan_stat.inv_found)
                    begin
                        evict_count_next = evict_count_reg + 32'd1;
                        evicted_next     = 1'b1;
                    end
                end
                if (!pass_reg)
                begin
                    first_hit_next = scan_stat.hit;
                end
                if (modify_reg && !pass_reg)
                begin
                    pass_next      = 1'b1;
                    rd_way_next    = '0;
                    scan_ctl.clear = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= RST_SET_BITS;
            way_count_reg  <= RST_WAY_COUNT;
            block_bits_reg <= RST_BLOCK_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_WAY_COUNT:  way_count_reg  <= cfg_data[3:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            rd_way_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            pass_reg        <= 1'b0;
            modify_reg      <= 1'b0;
            done_reg        <= 1'b0;
            first_hit_reg   <= 1'b0;
            evicted_reg     <= 1'b0;
            stamp_reg       <= '0;
            hit_count_reg   <= '0;
            miss_count_reg  <= '0;
            evict_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            rd_way_reg      <= rd_way_next;
            cmp_vld_reg     <= cmp_vld_next;
            pass_reg        <= pass_next;
            modify_reg      <= modify_next;
            done_reg        <= done_next;
            first_hit_reg   <= first_hit_next;
            evicted_reg     <= evicted_next;
            stamp_reg       <= stamp_next;
            hit_count_reg   <= hit_count_next;
            miss_count_reg  <= miss_count_next;
            evict_count_reg <= evict_count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        block_reg   <= block_next;
        set_reg     <= set_next;
        tag_reg     <= tag_next;
        cmp_way_reg <= cmp_way_next;
    end

    // Tag store.
    salru_ram #(
        .WIDTH (64),
        .DEPTH (LDEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (line_waddr),
        .wdata (tag_reg),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (tag_rdata)
    );

    // Timestamp store.
    salru_ram #(
        .WIDTH (32),
        .DEPTH (LDEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (stamp_next),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (stamp_rdata)
    );

    // Valid bits, one row per set.
    salru_ram #(
        .WIDTH (MAX_WAYS),
        .DEPTH (SETS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vrow_we),
        .waddr (vrow_waddr),
        .wdata (vrow_wdata),
        .re    (vrow_re),
        .raddr (set_reg),
        .rdata (vrow_rdata)
    );

    // Shared way compare unit.
    salru_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .way        (cmp_way_reg),
        .line_valid (vrow_rdata[cmp_way_reg]),
        .line_tag   (tag_rdata),
        .line_stamp (stamp_rdata),
        .tag        (tag_reg),
        .stat       (scan_stat),
        .hit_way    (hit_way),
        .inv_way    (inv_way),
        .victim_way (victim_way)
    );

    // Result beat.
    assign done                  = done_reg;
    assign result.first_hit      = first_hit_reg;
    assign result.evicted        = evicted_reg;
    assign result.hit_total      = hit_count_reg;
    assign result.miss_total     = miss_count_reg;
    assign result.eviction_total = evict_count_reg;

`ifndef SYNTH
    // A result beat is only given while the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // An item that hits first cannot also evict.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.first_hit && result.evicted))
        else $error("first hit together with eviction");

    // Totals move only on a write-back cycle.
    a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(hit_count_reg) || !$stable(miss_count_reg)) |->
            ($past(state_reg) == ST_WRITE))
        else $error("counter changed outside write-back");

    // A write-back always follows a scan.
    a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> ($past(state_reg) == ST_SCAN))
        else $error("write-back without scan");
`endif

endmodule

// ===== tb/tb_set_assoc_lru_cache_sim_core.sv =====
// Self-checking testbench for the set-associative LRU cache simulator core.
module tb_set_assoc_lru_cache_sim_core;
    import salru_pkg::*;

    localparam int SET_LIMIT     = DEF_MAX_SET_BITS;
    localparam int WAY_LIMIT     = DEF_MAX_WAYS;
    localparam int LINE_COUNT    = (1 << SET_LIMIT) * WAY_LIMIT;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int TRACE_LENGTH  = 1850;
    localparam int PRINT_LIMIT   = 40;
    // Register index with no register behind it; writes to it must change nothing.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    // Cache contents as the predictor sees them.
    logic [63:0] cached_tag [LINE_COUNT];
    bit          cached_valid [LINE_COUNT];
    logic [31:0] touch_stamp [LINE_COUNT];
    logic [31:0] stamp_clock;
    logic [31:0] hit_tally;
    logic [31:0] miss_tally;
    logic [31:0] evict_tally;

    // Register copies as the predictor sees them.
    logic [2:0]  cur_set_bits;
    logic [3:0]  cur_way_count;
    logic [5:0]  cur_block_bits;

    result_t     expected_results [$];
    int          cycle_count;
    int          error_count;
    int          access_count;
    bit          gaps_off;

    set_assoc_lru_cache_sim_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock with a period of 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count cycles and stop a run that hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h want %0h",
                     cycle_count, field, got, want);
    endtask

    // One cache access: lookup, fill of the first free way, or replacement of the LRU way.
    task automatic cache_touch(input logic [63:0] address, output logic hit,
                               inout logic evicted);
        int          sets_log;
        int          ways;
        int          base;
        int          victim;
        logic [63:0] block;
        logic [63:0] tag;
        sets_log = (cur_set_bits > SET_LIMIT) ? SET_LIMIT : int'(cur_set_bits);
        ways = (cur_way_count == 0) ? 1 : int'(cur_way_count);
        if (ways > WAY_LIMIT)
            ways = WAY_LIMIT;
        block = address >> cur_block_bits;
        tag = block >> sets_log;
        base = int'(block & ((64'd1 << sets_log) - 64'd1)) * WAY_LIMIT;
        hit = 1'b0;

        for (int w = 0; w < ways; w++)
        begin
            if (cached_valid[base + w] && cached_tag[base + w] == tag)
            begin
                stamp_clock++;
                touch_stamp[base + w] = stamp_clock;
                hit_tally++;
                hit = 1'b1;
                return;
            end
        end

        miss_tally++;
        for (int w = 0; w < ways; w++)
        begin
            if (!cached_valid[base + w])
            begin
                stamp_clock++;
                touch_stamp[base + w] = stamp_clock;
                cached_tag[base + w] = tag;
                cached_valid[base + w] = 1'b1;
                return;
            end
        end

        // Every way in use is valid: replace the oldest, lowest way on a tie.
        victim = 0;
        for (int w = 1; w < ways; w++)
        begin
            if (touch_stamp[base + w] < touch_stamp[base + victim])
                victim = w;
        end
        stamp_clock++;
        touch_stamp[base + victim] = stamp_clock;
        cached_tag[base + victim] = tag;
        cached_valid[base + victim] = 1'b1;
        evict_tally++;
        evicted = 1'b1;
    endtask

    // Work out the result beat of one trace record.
    task automatic predict_record(input request_t beat, output result_t outcome);
        logic hit_first;
        logic hit_second;
        logic evicted;
        hit_first = 1'b0;
        evicted = 1'b0;
        case (beat.action) inside
            ACT_IGNORE: ;
            ACT_LOAD, ACT_STORE:
                cache_touch(beat.address, hit_first, evicted);
            ACT_MODIFY:
            begin
                cache_touch(beat.address, hit_first, evicted);
                cache_touch(beat.address, hit_second, evicted);
            end
            default: ;
        endcase
        outcome.first_hit = hit_first;
        outcome.evicted = evicted;
        outcome.hit_total = hit_tally;
        outcome.miss_total = miss_tally;
        outcome.eviction_total = evict_tally;
    endtask

    // Send one trace record, with random idle cycles in front, and queue its result.
    task automatic send_record(input logic [1:0] action, input logic [63:0] address);
        request_t beat;
        result_t  outcome;
        bit       idled;
        beat.action = action;
        beat.address = address;
        idled = 1'b0;
        while (!gaps_off && $urandom_range(0, 99) < 18)
        begin
            if (!idled)
                start <= 1'b0;
            idled = 1'b1;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= beat;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_record(beat, outcome);
        expected_results.push_back(outcome);
        access_count++;
    endtask

    // Stop sending and wait until every result has come and the block is idle.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Write one register; valid stays high so that writes can follow back to back.
    task automatic write_register(input logic [1:0] index, input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (index)
            CFG_SET_BITS:   cur_set_bits = value[2:0];
            CFG_WAY_COUNT:  cur_way_count = value[3:0];
            CFG_BLOCK_BITS: cur_block_bits = value;
            default: ;
        endcase
    endtask

    task automatic release_config();
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Hits, fills and a one-way conflict under the reset configuration.
    task automatic check_reset_config_access();
        send_record(ACT_IGNORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_record(ACT_LOAD, 64'h0);
        send_record(ACT_LOAD, 64'hF);
        send_record(ACT_STORE, 64'h10);
        send_record(ACT_MODIFY, 64'h100);
        send_record(ACT_MODIFY, 64'h0);
        send_record(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_record(ACT_IGNORE, 64'h0);
    endtask

    // Fill a four-way set, refresh one line and check which lines get replaced.
    task automatic check_lru_replacement();
        wait_idle();
        write_register(CFG_SET_BITS, 6'd0);
        write_register(CFG_WAY_COUNT, 6'd4);
        write_register(CFG_BLOCK_BITS, 6'd0);
        release_config();
        send_record(ACT_LOAD, 64'd1);
        send_record(ACT_LOAD, 64'd2);
        send_record(ACT_LOAD, 64'd3);
        send_record(ACT_LOAD, 64'd4);
        send_record(ACT_LOAD, 64'd1);
        send_record(ACT_STORE, 64'd5);
        send_record(ACT_LOAD, 64'd2);
        send_record(ACT_LOAD, 64'd1);
    endtask

    // Register values beyond the array sizes, a zero way count and very large blocks.
    task automatic check_config_extremes();
        wait_idle();
        write_register(CFG_SET_BITS, 6'd7);
        write_register(CFG_WAY_COUNT, 6'd15);
        write_register(CFG_BLOCK_BITS, 6'd63);
        release_config();
        send_record(ACT_LOAD, 64'h8000_0000_0000_0000);
        send_record(ACT_LOAD, 64'h0);
        send_record(ACT_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);

        wait_idle();
        write_register(CFG_SET_BITS, 6'd0);
        write_register(CFG_WAY_COUNT, 6'd0);
        write_register(CFG_BLOCK_BITS, 6'd32);
        write_register(CFG_UNUSED, 6'h3F);
        release_config();
        send_record(ACT_LOAD, 64'h1_0000_0000);
        send_record(ACT_LOAD, 64'h1_FFFF_FFFF);
        send_record(ACT_STORE, 64'h2_0000_0000);

        wait_idle();
        write_register(CFG_BLOCK_BITS, 6'd33);
        release_config();
        send_record(ACT_MODIFY, 64'h3_0000_0000);
    endtask

    // Phases of random configuration, each with a trace built around a pool of hot lines.
    task automatic run_random_trace();
        logic [63:0] hot_lines [$];
        logic [63:0] address;
        logic [1:0]  action;
        logic [5:0]  value;
        int          phase;
        int          phase_end;
        int          pick;
        int          roll;
        int          sets_log;
        phase = 0;
        while (access_count < TRACE_LENGTH)
        begin
            wait_idle();
            gaps_off = (phase == 2);

            // New configuration; unwritten registers keep their values.
            if ($urandom_range(0, 99) < 80)
            begin
                value = {3'($urandom), 3'($urandom_range(0, 7))};
                if ($urandom_range(0, 3) != 0)
                    value[5:3] = 3'd0;
                write_register(CFG_SET_BITS, value);
            end
            if ($urandom_range(0, 99) < 80)
            begin
                value = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(1, 8))
                                                     : 6'($urandom_range(0, 15));
                if ($urandom_range(0, 3) == 0)
                    value[5:4] = 2'($urandom);
                write_register(CFG_WAY_COUNT, value);
            end
            if ($urandom_range(0, 99) < 80)
            begin
                value = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 8))
                                                     : 6'($urandom_range(0, 63));
                write_register(CFG_BLOCK_BITS, value);
            end
            release_config();

            hot_lines.delete();
            repeat ($urandom_range(2, 40))
                hot_lines.push_back(random_word());
            sets_log = (cur_set_bits > SET_LIMIT) ? SET_LIMIT : int'(cur_set_bits);
            phase_end = access_count + $urandom_range(100, 200);

            while (access_count < phase_end && access_count < TRACE_LENGTH)
            begin
                pick = $urandom_range(0, hot_lines.size() - 1);
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    // Reuse a hot line, anywhere within its block.
                    address = hot_lines[pick] ^
                              (random_word() & ((64'd1 << cur_block_bits) - 64'd1));
                end
                else if (roll < 75)
                begin
                    // Same set, new tag: forces conflicts and evictions.
                    hot_lines[pick] = hot_lines[pick] ^
                                      (random_word() << (int'(cur_block_bits) + sets_log));
                    address = hot_lines[pick];
                end
                else if (roll < 85)
                begin
                    address = random_word();
                end
                else
                begin
                    hot_lines[pick] = random_word();
                    address = hot_lines[pick];
                end

                roll = $urandom_range(0, 99);
                if (roll < 10)
                    action = ACT_IGNORE;
                else if (roll < 45)
                    action = ACT_LOAD;
                else if (roll < 70)
                    action = ACT_STORE;
                else
                    action = ACT_MODIFY;
                send_record(action, address);
            end
            phase++;
        end
        gaps_off = 1'b0;
    endtask

    // Compare each result beat with the oldest outstanding prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 64'(done), 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.first_hit !== want.first_hit)
                    report_mismatch("first_hit", 64'(result.first_hit), 64'(want.first_hit));
                if (result.evicted !== want.evicted)
                    report_mismatch("evicted", 64'(result.evicted), 64'(want.evicted));
                if (result.hit_total !== want.hit_total)
                    report_mismatch("hit_total", 64'(result.hit_total), 64'(want.hit_total));
                if (result.miss_total !== want.miss_total)
                    report_mismatch("miss_total", 64'(result.miss_total),
                                    64'(want.miss_total));
                if (result.eviction_total !== want.eviction_total)
                    report_mismatch("eviction_total", 64'(result.eviction_total),
                                    64'(want.eviction_total));
            end
        end
    end

    // Reset, directed checks, random trace, then the verdict.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SET_BITS;
        cfg_data = '0;
        error_count = 0;
        access_count = 0;
        gaps_off = 1'b0;
        stamp_clock = '0;
        hit_tally = '0;
        miss_tally = '0;
        evict_tally = '0;
        cur_set_bits = RST_SET_BITS;
        cur_way_count = RST_WAY_COUNT;
        cur_block_bits = RST_BLOCK_BITS;
        foreach (cached_valid[i])
            cached_valid[i] = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        check_reset_config_access();
        check_lru_replacement();
        check_config_extremes();
        run_random_trace();

        wait_idle();
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
